// ===== src/ppuf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppuf_pkg
// Shared types and constants for the partially persistent union-find block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppuf_pkg;

  localparam int NodeCountDef = 1024;
  localparam int TimeBitsDef  = 20;

  localparam int NodeFieldW = 10;
  localparam int TimeFieldW = 20;

  typedef enum logic [1:0] {
    ReqMergeAt   = 2'd0,
    ReqMergeNext = 2'd1,
    ReqQuery     = 2'd2
  } req_type_e;

  typedef struct packed {
    req_type_e              req_type;
    logic [NodeFieldW-1:0]  node_a;
    logic [NodeFieldW-1:0]  node_b;
    logic [TimeFieldW-1:0]  query_time;
  } in_t;

  typedef struct packed {
    logic                   flag;
    logic [NodeFieldW-1:0]  leader_a;
    logic [NodeFieldW-1:0]  leader_b;
    logic [TimeFieldW-1:0]  time_used;
  } out_t;

endpackage

`default_nettype wire

// ===== src/partially_persistent_union_find_top.sv =====
// ----------------------------------------------------------------------------
// partially_persistent_union_find_top
// Union-find with time-stamped root links, state held in one node memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid_i / in_stall_o / in_req_i: a request is taken at
//    a clock edge with valid high and stall low. Types: merge at a given time,
//    merge at the current time plus one, same-component query.
//  - Output channel out_valid_o / out_stall_i / out_res_o: exactly one result
//    per request, in request order. The result sits in an output register;
//    a stall holds it and the next request is still accepted meanwhile.
//  - One request at a time. A request is accepted, walks from node a, walks
//    from node b and is handed over; a merge that links also reads both
//    leaders' entries and writes both roots. Each walk step is one read of the
//    node memory (one registered read port), so the parent walks set the
//    request time; with union by size a walk is at most log2(NODE_COUNT) steps.
//    Merges at times older than existing links can relink inner nodes and
//    stretch a walk up to NODE_COUNT steps. A stalled result adds its wait.
//  - Out-of-range nodes and unknown request types skip the walks and go straight to the hand-over.
//  - Reset: the node memory is rewritten by a clearing pass over all
//    NODE_COUNT nodes (parent = self, link time 0, size 1); in_stall_o stays high
//    until it ends. The current-time counter resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module partially_persistent_union_find_top #(
  parameter int NODE_COUNT = ppuf_pkg::NodeCountDef,
  parameter int TIME_BITS  = ppuf_pkg::TimeBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_stall_o,
  input  wire ppuf_pkg::in_t  in_req_i,
  output      logic           out_valid_o,
  input  wire logic           out_stall_i,
  output      ppuf_pkg::out_t out_res_o
);

  import ppuf_pkg::*;

  localparam int NodeW = $clog2(NODE_COUNT);
  localparam int SizeW = $clog2(NODE_COUNT + 1);
  localparam int StepW = $clog2(NODE_COUNT + 1);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  // One memory word per node: parent link, link stamp, tree size.
  typedef struct packed {
    logic [NodeW-1:0]     parent;
    logic [TIME_BITS-1:0] ltime;
    logic [SizeW-1:0]     size;
  } entry_t;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SWalkA,
    SWalkB,
    SSizeA,
    SSizeB,
    SWrite,
    SFin
  } state_e;

  state_e               state_q;
  logic [NodeW-1:0]     clr_q;
  logic [NodeW-1:0]     x_q;
  logic [StepW-1:0]     steps_q;
  logic [NodeW-1:0]     b_q;
  logic [NodeW-1:0]     la_q;
  logic [NodeW-1:0]     lb_q;
  logic [TIME_BITS-1:0] t_q;
  logic [TIME_BITS-1:0] cur_q;
  req_type_e            kind_q;
  entry_t               ent_a_q;
  logic [NodeW-1:0]     big_q;
  entry_t               big_ent_q;
  out_t                 res_q;
  out_t                 out_q;
  logic                 out_valid_q;

  // node memory
  entry_t mem [NODE_COUNT];
  entry_t rd_q;
  logic [NodeW-1:0] rd_addr;
  logic             we;
  logic [NodeW-1:0] wr_addr;
  entry_t           wr_data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // request decode at accept
  logic                 in_range;
  logic [TIME_BITS-1:0] qt_clamped;
  logic [TIME_BITS-1:0] t_new;

  always_comb begin
    in_range = (32'(in_req_i.node_a) < 32'(NODE_COUNT)) &&
               (32'(in_req_i.node_b) < 32'(NODE_COUNT));
    if (32'(in_req_i.query_time) > 32'(TimeMax)) begin
      qt_clamped = TimeMax;
    end else begin
      qt_clamped = TIME_BITS'(in_req_i.query_time);
    end
    if (in_req_i.req_type == ReqMergeNext) begin
      t_new = (cur_q == TimeMax) ? TimeMax : cur_q + 1'b1;
    end else begin
      t_new = qt_clamped;
    end
  end

  // walk step: stop at a self-parent, a later link, a bad parent or the step cap
  logic step_stop;
  assign step_stop = (steps_q == StepW'(NODE_COUNT)) || (rd_q.parent == x_q) ||
                     (rd_q.ltime > t_q) || (32'(rd_q.parent) >= 32'(NODE_COUNT));

  // link choice: ties put leader a under leader b
  logic             a_bigger;
  logic [NodeW-1:0] small_node;
  logic [SizeW-1:0] small_size;
  logic [SizeW:0]   size_sum;
  logic [SizeW-1:0] size_sat;

  always_comb begin
    a_bigger   = ent_a_q.size > rd_q.size;
    small_node = a_bigger ? lb_q : la_q;
    small_size = a_bigger ? rd_q.size : ent_a_q.size;
    size_sum   = {1'b0, ent_a_q.size} + {1'b0, rd_q.size};
    if (32'(size_sum) > 32'(NODE_COUNT)) begin
      size_sat = SizeW'(NODE_COUNT);
    end else begin
      size_sat = size_sum[SizeW-1:0];
    end
  end

  // memory port control
  always_comb begin
    rd_addr = x_q;
    we      = 1'b0;
    wr_addr = clr_q;
    wr_data = '{parent: clr_q, ltime: '0, size: SizeW'(1)};
    case (state_q)
      SClear: begin
        we = 1'b1;
      end
      SIdle: begin
        rd_addr = NodeW'(in_req_i.node_a);
      end
      SWalkA: begin
        rd_addr = step_stop ? b_q : rd_q.parent;
      end
      SWalkB: begin
        rd_addr = step_stop ? la_q : rd_q.parent;
      end
      SSizeA: begin
        rd_addr = lb_q;
      end
      SSizeB: begin
        we      = 1'b1;
        wr_addr = small_node;
        wr_data = '{parent: a_bigger ? la_q : lb_q, ltime: t_q, size: small_size};
      end
      SWrite: begin
        we      = 1'b1;
        wr_addr = big_q;
        wr_data = big_ent_q;
      end
      default: begin
        rd_addr = x_q;
      end
    endcase
  end

  // output register loads once the previous result is gone or leaving
  logic out_load;
  assign out_load = (state_q == SFin) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      x_q         <= '0;
      steps_q     <= '0;
      b_q         <= '0;
      la_q        <= '0;
      lb_q        <= '0;
      t_q         <= '0;
      cur_q       <= '0;
      kind_q      <= ReqMergeAt;
      ent_a_q     <= '0;
      big_q       <= '0;
      big_ent_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NodeW'(NODE_COUNT - 1)) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (in_valid_i) begin
            kind_q  <= in_req_i.req_type;
            t_q     <= t_new;
            x_q     <= NodeW'(in_req_i.node_a);
            b_q     <= NodeW'(in_req_i.node_b);
            steps_q <= '0;
            if (in_req_i.req_type != ReqMergeAt && in_req_i.req_type != ReqMergeNext &&
                in_req_i.req_type != ReqQuery) begin
              res_q   <= '0;
              state_q <= SFin;
            end else if (!in_range) begin
              res_q   <= '{flag: 1'b0, leader_a: in_req_i.node_a,
                           leader_b: in_req_i.node_b, time_used: TimeFieldW'(t_new)};
              state_q <= SFin;
            end else begin
              state_q <= SWalkA;
            end
          end
        end
        SWalkA: begin
          if (step_stop) begin
            la_q    <= x_q;
            x_q     <= b_q;
            steps_q <= '0;
            state_q <= SWalkB;
          end else begin
            x_q     <= rd_q.parent;
            steps_q <= steps_q + 1'b1;
          end
        end
        SWalkB: begin
          if (step_stop) begin
            lb_q            <= x_q;
            res_q.leader_a  <= NodeFieldW'(la_q);
            res_q.leader_b  <= NodeFieldW'(x_q);
            res_q.time_used <= TimeFieldW'(t_q);
            res_q.flag      <= (kind_q == ReqQuery) && (la_q == x_q);
            if (kind_q != ReqQuery && la_q != x_q) begin
              state_q <= SSizeA;
            end else begin
              state_q <= SFin;
            end
          end else begin
            x_q     <= rd_q.parent;
            steps_q <= steps_q + 1'b1;
          end
        end
        SSizeA: begin
          ent_a_q <= rd_q;
          state_q <= SSizeB;
        end
        SSizeB: begin
          // small root is written now, the big root's size next cycle
          big_q            <= a_bigger ? la_q : lb_q;
          big_ent_q.parent <= a_bigger ? ent_a_q.parent : rd_q.parent;
          big_ent_q.ltime  <= a_bigger ? ent_a_q.ltime : rd_q.ltime;
          big_ent_q.size   <= size_sat;
          state_q          <= SWrite;
        end
        SWrite: begin
          res_q.flag <= 1'b1;
          if (kind_q == ReqMergeNext && cur_q != TimeMax) begin
            cur_q <= cur_q + 1'b1;
          end
          state_q <= SFin;
        end
        SFin: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire
